// ===== hdl/http_response_header_parser_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros shared by the response header parser
// ---------------------------------------------------------------------------
`ifndef HTTP_RESPONSE_HEADER_PARSER_MACROS_SVH
`define HTTP_RESPONSE_HEADER_PARSER_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define HRHP_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Check that a consequent holds in the cycle after its antecedent.
`define HRHP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/hrhp_pkg.sv =====
// ---------------------------------------------------------------------------
// hrhp_pkg
// Types, character codes and roles for the response header parser.
// ---------------------------------------------------------------------------
package hrhp_pkg;

  typedef enum logic [3:0] {
    ST_DONE         = 4'd0,
    ST_PROTOCOL     = 4'd1,
    ST_BEFORE_MAJOR = 4'd2,
    ST_MAJOR        = 4'd3,
    ST_BEFORE_MINOR = 4'd4,
    ST_MINOR        = 4'd5,
    ST_BEFORE_CODE  = 4'd6,
    ST_CODE         = 4'd7,
    ST_BEFORE_TEXT  = 4'd8,
    ST_TEXT         = 4'd9,
    ST_BEFORE_LF    = 4'd10,
    ST_BEFORE_KEY   = 4'd11,
    ST_KEY          = 4'd12,
    ST_BEFORE_SEP   = 4'd13,
    ST_BEFORE_VALUE = 4'd14,
    ST_VALUE        = 4'd15
  } parse_state_t;

  localparam int NumWidth = 10;

  typedef logic [NumWidth-1:0] num_val_t;

  // Running number field: value, digit count and stop flag.
  typedef struct packed {
    num_val_t   acc;
    logic [1:0] taken;
    logic       stopped;
  } num_t;

  localparam logic [2:0] ROLE_OTHER  = 3'd0;
  localparam logic [2:0] ROLE_NUMBER = 3'd1;
  localparam logic [2:0] ROLE_TEXT   = 3'd2;
  localparam logic [2:0] ROLE_KEY    = 3'd3;
  localparam logic [2:0] ROLE_VALUE  = 3'd4;

  localparam logic [7:0] CH_H     = 8'h48;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [1:0] MaxDigits = 2'd3;

  // Expected byte of the protocol name at a given position.
  function automatic logic [7:0] magic_char(input logic [1:0] idx);
    logic [7:0] c;
    case (idx)
      2'd0:    c = CH_H;
      2'd1:    c = CH_T;
      2'd2:    c = CH_T;
      default: c = CH_P;
    endcase
    return c;
  endfunction

endpackage

// ===== hdl/http_response_header_parser.sv =====
// ---------------------------------------------------------------------------
// http_response_header_parser
// Byte-wide HTTP response status line and header parser.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one response byte per transfer
//   with first set on the first byte of each response. Output channel
//   (out_valid/out_ready) returns one result per input byte: the byte, its
//   role, the terminator flags and the parsed version and status code.
// Throughput and output:
//   One byte per cycle unless stalled. A byte's result appears in the
//   cycle after its transfer, from the output register. All parsing of a
//   byte is one combinational pass from the parser state to that register.
// Stall:
//   While a result waits, the next byte is still taken in the same cycle
//   that the receiver takes the waiting result; with out_ready low and a
//   result pending, in_ready is low and the result holds.
// Reset:
//   rst (synchronous) empties the output register and puts the parser in
//   its idle state, where bytes are ignored until one with first set.
// ---------------------------------------------------------------------------
`include "http_response_header_parser_macros.svh"

module http_response_header_parser (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] data_byte,
  input  logic       first,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] byte_out,
  output logic [2:0] role,
  output logic       key_end,
  output logic       value_end,
  output logic       status_line_done,
  output logic       header_end,
  output logic       rejected,
  output logic [9:0] major_version,
  output logic [9:0] minor_version,
  output logic [9:0] status_code
);

  hrhp_pkg::parse_state_t parse_state, parse_state_next;
  logic [2:0]         byte_position, byte_position_next;
  hrhp_pkg::num_t     num, num_next;
  hrhp_pkg::num_val_t major_reg, major_reg_next;
  hrhp_pkg::num_val_t minor_reg, minor_reg_next;
  hrhp_pkg::num_val_t code_reg, code_reg_next;

  logic [2:0] role_next;
  logic       key_end_next, value_end_next, status_done_next;
  logic       header_end_next, rejected_next;
  logic       in_xfer;

  assign in_ready = !out_valid || out_ready;
  assign in_xfer  = in_valid && in_ready;

  assign major_version = major_reg;
  assign minor_version = minor_reg;
  assign status_code   = code_reg;

  // Take one byte into a number field: at most three leading digits.
  function automatic hrhp_pkg::num_t num_take(input hrhp_pkg::num_t n,
                                              input logic [7:0] b);
    hrhp_pkg::num_t     r;
    hrhp_pkg::num_val_t x10;
    r = n;
    x10 = hrhp_pkg::num_val_t'((n.acc << 3) + (n.acc << 1));
    if (!n.stopped && n.taken < hrhp_pkg::MaxDigits &&
        b >= hrhp_pkg::CH_ZERO && b <= hrhp_pkg::CH_NINE) begin
      r.acc   = x10 + hrhp_pkg::num_val_t'(b[3:0]);
      r.taken = n.taken + 2'd1;
    end else begin
      r.stopped = 1'b1;
    end
    return r;
  endfunction

  always_comb begin
    parse_state_next   = parse_state;
    byte_position_next = byte_position;
    num_next           = num;
    major_reg_next     = major_reg;
    minor_reg_next     = minor_reg;
    code_reg_next      = code_reg;
    role_next          = hrhp_pkg::ROLE_OTHER;
    key_end_next       = 1'b0;
    value_end_next     = 1'b0;
    status_done_next   = 1'b0;
    header_end_next    = 1'b0;
    rejected_next      = 1'b0;

    if (first) begin
      parse_state_next   = hrhp_pkg::ST_PROTOCOL;
      byte_position_next = 3'd0;
      num_next           = '0;
      major_reg_next     = '0;
      minor_reg_next     = '0;
      code_reg_next      = '0;
    end

    // Check the protocol name over the first four bytes.
    if (parse_state_next != hrhp_pkg::ST_DONE && !byte_position_next[2] &&
        data_byte != hrhp_pkg::magic_char(byte_position_next[1:0])) begin
      rejected_next    = 1'b1;
      parse_state_next = hrhp_pkg::ST_DONE;
    end
    if (!byte_position_next[2]) begin
      byte_position_next = byte_position_next + 3'd1;
    end

    // Fall through the states in order, as one byte may pass several.
    if (parse_state_next == hrhp_pkg::ST_PROTOCOL && data_byte == hrhp_pkg::CH_SLASH) begin
      parse_state_next = hrhp_pkg::ST_BEFORE_MAJOR;
    end
    if (parse_state_next == hrhp_pkg::ST_BEFORE_MAJOR && data_byte != hrhp_pkg::CH_SLASH) begin
      num_next         = '0;
      parse_state_next = hrhp_pkg::ST_MAJOR;
    end
    if (parse_state_next == hrhp_pkg::ST_MAJOR) begin
      if (data_byte == hrhp_pkg::CH_DOT) begin
        major_reg_next   = num_next.acc;
        parse_state_next = hrhp_pkg::ST_BEFORE_MINOR;
      end else begin
        num_next  = num_take(num_next, data_byte);
        role_next = hrhp_pkg::ROLE_NUMBER;
      end
    end
    if (parse_state_next == hrhp_pkg::ST_BEFORE_MINOR && data_byte != hrhp_pkg::CH_DOT) begin
      num_next         = '0;
      parse_state_next = hrhp_pkg::ST_MINOR;
    end
    if (parse_state_next == hrhp_pkg::ST_MINOR) begin
      if (data_byte == hrhp_pkg::CH_SPACE) begin
        minor_reg_next   = num_next.acc;
        parse_state_next = hrhp_pkg::ST_BEFORE_CODE;
      end else begin
        num_next  = num_take(num_next, data_byte);
        role_next = hrhp_pkg::ROLE_NUMBER;
      end
    end
    if (parse_state_next == hrhp_pkg::ST_BEFORE_CODE && data_byte != hrhp_pkg::CH_SPACE) begin
      num_next         = '0;
      parse_state_next = hrhp_pkg::ST_CODE;
    end
    if (parse_state_next == hrhp_pkg::ST_CODE) begin
      if (data_byte == hrhp_pkg::CH_SPACE) begin
        code_reg_next    = num_next.acc;
        parse_state_next = hrhp_pkg::ST_BEFORE_TEXT;
      end else if (data_byte == hrhp_pkg::CH_CR) begin
        code_reg_next    = num_next.acc;
        status_done_next = 1'b1;
        parse_state_next = hrhp_pkg::ST_BEFORE_LF;
      end else begin
        num_next  = num_take(num_next, data_byte);
        role_next = hrhp_pkg::ROLE_NUMBER;
      end
    end
    if (parse_state_next == hrhp_pkg::ST_BEFORE_TEXT && data_byte != hrhp_pkg::CH_SPACE) begin
      parse_state_next = hrhp_pkg::ST_TEXT;
    end
    if (parse_state_next == hrhp_pkg::ST_TEXT) begin
      if (data_byte == hrhp_pkg::CH_CR) begin
        status_done_next = 1'b1;
        parse_state_next = hrhp_pkg::ST_BEFORE_LF;
      end else begin
        role_next = hrhp_pkg::ROLE_TEXT;
      end
    end
    if (parse_state_next == hrhp_pkg::ST_BEFORE_LF && data_byte == hrhp_pkg::CH_LF) begin
      parse_state_next = hrhp_pkg::ST_BEFORE_KEY;
    end
    if (parse_state_next == hrhp_pkg::ST_BEFORE_KEY && data_byte != hrhp_pkg::CH_LF) begin
      parse_state_next = hrhp_pkg::ST_KEY;
    end
    if (parse_state_next == hrhp_pkg::ST_KEY) begin
      if (data_byte == hrhp_pkg::CH_CR) begin
        header_end_next  = 1'b1;
        parse_state_next = hrhp_pkg::ST_DONE;
      end else if (data_byte == hrhp_pkg::CH_SPACE || data_byte == hrhp_pkg::CH_COLON) begin
        key_end_next     = 1'b1;
        parse_state_next = hrhp_pkg::ST_BEFORE_SEP;
      end else begin
        role_next = hrhp_pkg::ROLE_KEY;
      end
    end
    if (parse_state_next == hrhp_pkg::ST_BEFORE_SEP && data_byte == hrhp_pkg::CH_COLON) begin
      parse_state_next = hrhp_pkg::ST_BEFORE_VALUE;
    end
    if (parse_state_next == hrhp_pkg::ST_BEFORE_VALUE && data_byte != hrhp_pkg::CH_SPACE &&
        data_byte != hrhp_pkg::CH_COLON) begin
      parse_state_next = hrhp_pkg::ST_VALUE;
    end
    if (parse_state_next == hrhp_pkg::ST_VALUE) begin
      if (data_byte == hrhp_pkg::CH_CR) begin
        value_end_next   = 1'b1;
        parse_state_next = hrhp_pkg::ST_BEFORE_LF;
      end else begin
        role_next = hrhp_pkg::ROLE_VALUE;
      end
    end
  end

  // Parser state advances on each input transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      parse_state   <= hrhp_pkg::ST_DONE;
      byte_position <= 3'd0;
      num           <= '0;
      major_reg     <= '0;
      minor_reg     <= '0;
      code_reg      <= '0;
    end else if (in_xfer) begin
      parse_state   <= parse_state_next;
      byte_position <= byte_position_next;
      num           <= num_next;
      major_reg     <= major_reg_next;
      minor_reg     <= minor_reg_next;
      code_reg      <= code_reg_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_xfer) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      byte_out         <= data_byte;
      role             <= role_next;
      key_end          <= key_end_next;
      value_end        <= value_end_next;
      status_line_done <= status_done_next;
      header_end       <= header_end_next;
      rejected         <= rejected_next;
    end
  end

  `HRHP_ASSERT_ALWAYS(a_one_terminator,
    !out_valid || $onehot0({key_end, value_end, status_line_done, header_end}),
    "more than one terminator flag on a result")
  `HRHP_ASSERT_ALWAYS(a_reject_plain,
    !(out_valid && rejected) || (role == hrhp_pkg::ROLE_OTHER && !key_end && !value_end &&
      !status_line_done && !header_end),
    "rejected byte carries a role or terminator")
  `HRHP_ASSERT_NEXT(a_first_bad_rejects,
    in_xfer && first && data_byte != hrhp_pkg::CH_H,
    out_valid && rejected && parse_state == hrhp_pkg::ST_DONE,
    "bad first byte not rejected")
  `HRHP_ASSERT_NEXT(a_first_clears_numbers,
    in_xfer && first,
    out_valid && major_version == '0 && minor_version == '0 && status_code == '0,
    "first byte did not clear parsed numbers")

endmodule

// ===== bench/tb_http_response_header_parser.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_http_response_header_parser
// Self-checking bench for the byte-wide response header parser: a queue-fed
// driver sends response bytes, a monitor checks every result against a
// bit-exact predictor, under several pacing mixes and one long receiver
// hold-off.
// ---------------------------------------------------------------------------
module tb_http_response_header_parser;

  localparam int ClkHalf       = 5;
  localparam int ResetCycles   = 6;
  localparam int PhaseBytes    = 360;
  localparam int HoldOffCycles = 400;
  localparam int IdleLimit     = 5000;
  localparam int DrainCycles   = 8;

  localparam logic [31:0] ProtoName = {hrhp_pkg::CH_H, hrhp_pkg::CH_T, hrhp_pkg::CH_T,
                                       hrhp_pkg::CH_P};
  localparam logic [7:0]  CH_DASH   = 8'h2D;
  localparam logic [7:0]  CH_FILL   = 8'h6B;

  typedef struct packed {
    logic [7:0] data;
    logic       first;
  } stream_byte_t;

  typedef struct packed {
    logic [7:0]         data;
    logic [2:0]         role;
    logic               key_end;
    logic               value_end;
    logic               status_done;
    logic               header_end;
    logic               rejected;
    hrhp_pkg::num_val_t major;
    hrhp_pkg::num_val_t minor;
    hrhp_pkg::num_val_t code;
  } parse_result_t;

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       in_valid  = 1'b0;
  logic       in_ready;
  logic [7:0] data_byte = 8'h00;
  logic       first     = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] byte_out;
  logic [2:0] role;
  logic       key_end;
  logic       value_end;
  logic       status_line_done;
  logic       header_end;
  logic       rejected;
  logic [9:0] major_version;
  logic [9:0] minor_version;
  logic [9:0] status_code;

  http_response_header_parser dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .data_byte        (data_byte),
    .first            (first),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .byte_out         (byte_out),
    .role             (role),
    .key_end          (key_end),
    .value_end        (value_end),
    .status_line_done (status_line_done),
    .header_end       (header_end),
    .rejected         (rejected),
    .major_version    (major_version),
    .minor_version    (minor_version),
    .status_code      (status_code)
  );

  always #ClkHalf clk = ~clk;

  stream_byte_t  pending_q[$];
  parse_result_t expected_q[$];
  logic [7:0]    msg_q[$];
  stream_byte_t  drive_item;
  parse_result_t want_res;

  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;
  bit          hold_armed    = 1'b0;
  bit          hold_done     = 1'b0;
  int unsigned hold_left     = 0;
  int unsigned idle_cycles   = 0;
  int unsigned mismatches    = 0;
  int unsigned bytes_queued  = 0;
  int unsigned bytes_sent    = 0;
  int unsigned results_seen  = 0;
  int unsigned responses     = 0;
  int unsigned rejects_seen  = 0;
  int unsigned headers_seen  = 0;

  // Predictor state, starting from the post-reset idle state.
  hrhp_pkg::parse_state_t st_q    = hrhp_pkg::ST_DONE;
  logic [2:0]             pos_q   = '0;
  hrhp_pkg::num_t         num_q   = '0;
  hrhp_pkg::num_val_t     major_q = '0;
  hrhp_pkg::num_val_t     minor_q = '0;
  hrhp_pkg::num_val_t     code_q  = '0;

  function automatic void take_digit(input logic [7:0] b);
    if (!num_q.stopped && num_q.taken < hrhp_pkg::MaxDigits &&
        b >= hrhp_pkg::CH_ZERO && b <= hrhp_pkg::CH_NINE) begin
      num_q.acc   = hrhp_pkg::num_val_t'(num_q.acc * 10 + (b - hrhp_pkg::CH_ZERO));
      num_q.taken = num_q.taken + 2'd1;
    end else begin
      num_q.stopped = 1'b1;
    end
  endfunction

  function automatic parse_result_t predict_byte(input logic [7:0] b, input logic f);
    parse_result_t          r;
    hrhp_pkg::parse_state_t s;
    r = '0;
    r.data = b;
    if (f) begin
      num_q   = '0;
      pos_q   = '0;
      major_q = '0;
      minor_q = '0;
      code_q  = '0;
      st_q    = hrhp_pkg::ST_PROTOCOL;
    end
    s = st_q;
    if (s != hrhp_pkg::ST_DONE && pos_q < 3'd4 && b != ProtoName[8*(3 - pos_q[1:0]) +: 8]) begin
      r.rejected = 1'b1;
      s = hrhp_pkg::ST_DONE;
    end
    if (pos_q < 3'd4) pos_q = pos_q + 3'd1;

    if (s == hrhp_pkg::ST_PROTOCOL && b == hrhp_pkg::CH_SLASH) s = hrhp_pkg::ST_BEFORE_MAJOR;
    if (s == hrhp_pkg::ST_BEFORE_MAJOR && b != hrhp_pkg::CH_SLASH) begin
      num_q = '0;
      s = hrhp_pkg::ST_MAJOR;
    end
    if (s == hrhp_pkg::ST_MAJOR) begin
      if (b == hrhp_pkg::CH_DOT) begin
        major_q = num_q.acc;
        s = hrhp_pkg::ST_BEFORE_MINOR;
      end else begin
        take_digit(b);
        r.role = hrhp_pkg::ROLE_NUMBER;
      end
    end
    if (s == hrhp_pkg::ST_BEFORE_MINOR && b != hrhp_pkg::CH_DOT) begin
      num_q = '0;
      s = hrhp_pkg::ST_MINOR;
    end
    if (s == hrhp_pkg::ST_MINOR) begin
      if (b == hrhp_pkg::CH_SPACE) begin
        minor_q = num_q.acc;
        s = hrhp_pkg::ST_BEFORE_CODE;
      end else begin
        take_digit(b);
        r.role = hrhp_pkg::ROLE_NUMBER;
      end
    end
    if (s == hrhp_pkg::ST_BEFORE_CODE && b != hrhp_pkg::CH_SPACE) begin
      num_q = '0;
      s = hrhp_pkg::ST_CODE;
    end
    if (s == hrhp_pkg::ST_CODE) begin
      if (b == hrhp_pkg::CH_SPACE || b == hrhp_pkg::CH_CR) begin
        code_q = num_q.acc;
        if (b == hrhp_pkg::CH_SPACE) begin
          s = hrhp_pkg::ST_BEFORE_TEXT;
        end else begin
          s = hrhp_pkg::ST_BEFORE_LF;
          r.status_done = 1'b1;
        end
      end else begin
        take_digit(b);
        r.role = hrhp_pkg::ROLE_NUMBER;
      end
    end
    if (s == hrhp_pkg::ST_BEFORE_TEXT && b != hrhp_pkg::CH_SPACE) s = hrhp_pkg::ST_TEXT;
    if (s == hrhp_pkg::ST_TEXT) begin
      if (b == hrhp_pkg::CH_CR) begin
        r.status_done = 1'b1;
        s = hrhp_pkg::ST_BEFORE_LF;
      end else begin
        r.role = hrhp_pkg::ROLE_TEXT;
      end
    end
    if (s == hrhp_pkg::ST_BEFORE_LF && b == hrhp_pkg::CH_LF) s = hrhp_pkg::ST_BEFORE_KEY;
    if (s == hrhp_pkg::ST_BEFORE_KEY && b != hrhp_pkg::CH_LF) s = hrhp_pkg::ST_KEY;
    if (s == hrhp_pkg::ST_KEY) begin
      if (b == hrhp_pkg::CH_CR) begin
        r.header_end = 1'b1;
        s = hrhp_pkg::ST_DONE;
      end else if (b == hrhp_pkg::CH_SPACE || b == hrhp_pkg::CH_COLON) begin
        r.key_end = 1'b1;
        s = hrhp_pkg::ST_BEFORE_SEP;
      end else begin
        r.role = hrhp_pkg::ROLE_KEY;
      end
    end
    if (s == hrhp_pkg::ST_BEFORE_SEP && b == hrhp_pkg::CH_COLON) s = hrhp_pkg::ST_BEFORE_VALUE;
    if (s == hrhp_pkg::ST_BEFORE_VALUE && b != hrhp_pkg::CH_SPACE && b != hrhp_pkg::CH_COLON) begin
      s = hrhp_pkg::ST_VALUE;
    end
    if (s == hrhp_pkg::ST_VALUE) begin
      if (b == hrhp_pkg::CH_CR) begin
        r.value_end = 1'b1;
        s = hrhp_pkg::ST_BEFORE_LF;
      end else begin
        r.role = hrhp_pkg::ROLE_VALUE;
      end
    end
    st_q    = s;
    r.major = major_q;
    r.minor = minor_q;
    r.code  = code_q;
    return r;
  endfunction

  // ---- stimulus construction ----

  task automatic queue_byte(input logic [7:0] b, input logic f);
    stream_byte_t item;
    item.data  = b;
    item.first = f;
    pending_q.push_back(item);
    bytes_queued++;
    if (f) responses++;
  endtask

  task automatic queue_str(input string s, input logic f);
    for (int i = 0; i < s.len(); i++) queue_byte(s[i], f && i == 0);
  endtask

  function automatic logic [7:0] any_but(input logic [7:0] bad);
    logic [7:0] c;
    c = 8'($urandom_range(255));
    if (c == bad) c = CH_FILL;
    return c;
  endfunction

  task automatic add_number(input logic [7:0] stop_a, input logic [7:0] stop_b);
    logic [7:0] c;
    // A leading sign stops the digit run at once and the field reads as zero.
    if ($urandom_range(7) == 0) msg_q.push_back(CH_DASH);
    repeat ($urandom_range(4)) msg_q.push_back(8'(hrhp_pkg::CH_ZERO + $urandom_range(9)));
    if ($urandom_range(9) == 0) begin
      c = 8'($urandom_range(255));
      if (c != stop_a && c != stop_b) msg_q.push_back(c);
    end
  endtask

  task automatic add_message();
    int unsigned kind;
    int unsigned cut;
    logic [7:0]  c;
    kind = $urandom_range(99);
    msg_q.delete();
    if (kind < 8) begin
      repeat ($urandom_range(12, 1)) begin
        queue_byte(8'($urandom_range(255)), $urandom_range(15) == 0);
      end
    end else begin
      for (int i = 0; i < 4; i++) msg_q.push_back(ProtoName[8*(3 - i) +: 8]);
      msg_q.push_back(hrhp_pkg::CH_SLASH);
      if ($urandom_range(5) == 0) msg_q.push_back(hrhp_pkg::CH_SLASH);
      add_number(hrhp_pkg::CH_DOT, hrhp_pkg::CH_DOT);
      msg_q.push_back(hrhp_pkg::CH_DOT);
      if ($urandom_range(5) == 0) msg_q.push_back(hrhp_pkg::CH_DOT);
      add_number(hrhp_pkg::CH_SPACE, hrhp_pkg::CH_SPACE);
      msg_q.push_back(hrhp_pkg::CH_SPACE);
      if ($urandom_range(5) == 0) msg_q.push_back(hrhp_pkg::CH_SPACE);
      add_number(hrhp_pkg::CH_SPACE, hrhp_pkg::CH_CR);
      if ($urandom_range(3) != 0) begin
        msg_q.push_back(hrhp_pkg::CH_SPACE);
        repeat ($urandom_range(8)) msg_q.push_back(any_but(hrhp_pkg::CH_CR));
      end
      msg_q.push_back(hrhp_pkg::CH_CR);
      // Put junk between CR and LF now and then.
      if ($urandom_range(9) == 0) msg_q.push_back(any_but(hrhp_pkg::CH_LF));
      msg_q.push_back(hrhp_pkg::CH_LF);
      repeat ($urandom_range(3)) begin
        repeat ($urandom_range(6, 1)) begin
          c = 8'($urandom_range(255));
          if (c == hrhp_pkg::CH_CR || c == hrhp_pkg::CH_SPACE || c == hrhp_pkg::CH_COLON) begin
            c = CH_FILL;
          end
          msg_q.push_back(c);
        end
        case ($urandom_range(3))
          0: msg_q.push_back(hrhp_pkg::CH_COLON);
          1: begin
            msg_q.push_back(hrhp_pkg::CH_SPACE);
            msg_q.push_back(hrhp_pkg::CH_COLON);
          end
          2: begin
            msg_q.push_back(hrhp_pkg::CH_COLON);
            msg_q.push_back(hrhp_pkg::CH_SPACE);
          end
          default: begin
            msg_q.push_back(hrhp_pkg::CH_SPACE);
            msg_q.push_back(any_but(hrhp_pkg::CH_COLON));
            msg_q.push_back(hrhp_pkg::CH_COLON);
          end
        endcase
        repeat ($urandom_range(8)) msg_q.push_back(any_but(hrhp_pkg::CH_CR));
        msg_q.push_back(hrhp_pkg::CH_CR);
        msg_q.push_back(hrhp_pkg::CH_LF);
      end
      msg_q.push_back(hrhp_pkg::CH_CR);
      if ($urandom_range(3) == 0) begin
        repeat ($urandom_range(3, 1)) msg_q.push_back(8'($urandom_range(255)));
      end
      // Break a share of the messages: bad protocol name, a stray byte, early end.
      if (kind < 12) begin
        msg_q[$urandom_range(3)] = 8'($urandom_range(255));
      end else if (kind < 16) begin
        msg_q[$urandom_range(msg_q.size() - 1)] = 8'($urandom_range(255));
      end else if (kind < 20) begin
        cut = $urandom_range(msg_q.size() - 1, 1);
        while (msg_q.size() > cut) void'(msg_q.pop_back());
      end
      foreach (msg_q[i]) queue_byte(msg_q[i], i == 0);
    end
  endtask

  task automatic add_directed();
    // Bytes ahead of any first byte are ignored.
    queue_byte(8'h00, 1'b0);
    queue_byte(8'hFF, 1'b0);
    // Rejection in the protocol name, then the rest of that response is ignored.
    queue_str("HXZ", 1'b1);
    queue_byte(8'hFF, 1'b1);
    // Four-digit major keeps three digits, minor starting with a letter reads
    // as zero, CR before LF, key ended by a space, header end, trailing byte.
    queue_str("HTTP/1234.x 7 O\r\r\nA :b\r\n\r\nZ", 1'b1);
  endtask

  // ---- driver ----

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_q.push_back(predict_byte(data_byte, first));
        bytes_sent++;
      end
      // Hold the payload until the transfer completes.
      if (!in_valid || in_ready) begin
        if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          drive_item = pending_q.pop_front();
          in_valid  <= 1'b1;
          data_byte <= drive_item.data;
          first     <= drive_item.first;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---- receiver hold-off counter ----

  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_armed && !hold_done) begin
      hold_left <= HoldOffCycles;
      hold_done <= 1'b1;
    end
  end

  // ---- monitor ----

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t: result %0d %s expected %0d actual %0d",
               $time, results_seen, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          $display("%0t: result with no byte outstanding, expected none actual byte %0d",
                   $time, byte_out);
          mismatches++;
        end else begin
          want_res = expected_q.pop_front();
          check_field("byte_out", want_res.data, byte_out);
          check_field("role", want_res.role, role);
          check_field("key_end", want_res.key_end, key_end);
          check_field("value_end", want_res.value_end, value_end);
          check_field("status_line_done", want_res.status_done, status_line_done);
          check_field("header_end", want_res.header_end, header_end);
          check_field("rejected", want_res.rejected, rejected);
          check_field("major_version", want_res.major, major_version);
          check_field("minor_version", want_res.minor, minor_version);
          check_field("status_code", want_res.code, status_code);
        end
        results_seen++;
        if (header_end) headers_seen++;
        if (rejected) rejects_seen++;
      end
      // Hold off the receiver once for a long stretch so the input backs up.
      if (hold_left != 0 || (hold_armed && !hold_done)) begin
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // ---- watchdog ----

  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else if (pending_q.size() != 0 || in_valid || expected_q.size() != 0) begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IdleLimit) begin
        $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
        $display("tb_http_response_header_parser: FAIL");
        $finish;
      end
    end
  end

  // ---- sequencing ----

  initial begin
    int unsigned phase_start;
    repeat (ResetCycles) @(posedge clk);
    rst <= 1'b0;
    for (int phase = 0; phase < 4; phase++) begin
      @(negedge clk);
      // Pacing: free-running with the hold-off, sender idle, receiver stall, mixed.
      case (phase)
        0: begin
          send_idle_pct = 0;
          stall_pct     = 0;
          hold_armed    = 1'b1;
          add_directed();
        end
        1: begin
          send_idle_pct = 86;
          stall_pct     = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct     = 86;
        end
        default: begin
          send_idle_pct = 15;
          stall_pct     = 15;
        end
      endcase
      phase_start = bytes_queued;
      while (bytes_queued - phase_start < PhaseBytes) add_message();
      while (pending_q.size() != 0 || in_valid || expected_q.size() != 0) @(negedge clk);
    end
    repeat (DrainCycles) @(posedge clk);
    $display("Sent %0d bytes in %0d responses; checked %0d results",
             bytes_sent, responses, results_seen);
    $display("(%0d rejected, %0d header ends); pacing: free-running, sender idle,",
             rejects_seen, headers_seen);
    $display("receiver stall, mixed; one %0d-cycle hold-off", HoldOffCycles);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("tb_http_response_header_parser: PASS");
    end else begin
      $display("tb_http_response_header_parser: FAIL");
    end
    $finish;
  end

endmodule

// ===== http_response_header_parser.f =====
+incdir+hdl
hdl/hrhp_pkg.sv
hdl/http_response_header_parser.sv
bench/tb_http_response_header_parser.sv
